// ===== src/phl_pkg.sv =====
// Shared types and constants of the per-thread load histogram.
package phl_pkg;

	// Fixed field widths
	localparam int KEY_W    = 64;
	localparam int LOAD_W   = 16;
	localparam int COUNT_W  = 32;
	localparam int SUM_W    = 40;
	localparam int BIN_W    = 6;
	localparam int SLOT_W   = 5;

	// Histogram layout: 50 two-percent bins plus the idle bin
	localparam int BIN_TOTAL = 51;
	localparam logic [BIN_W-1:0] IDLE_BIN = 6'd50;
	localparam logic [BIN_W-1:0] NO_BIN   = 6'd51;
	localparam int PCT_PER_BIN   = 2;
	localparam int MAX_WHOLE_PCT = 99;
	localparam int LOW_START_PCT = 101;

	// Saturation limits
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

	// Request codes
	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;

	// Per-entry statistics, one word of the stats memory
	typedef struct packed {
		logic [COUNT_W-1:0] samples;
		logic [COUNT_W-1:0] busy;
		logic [SUM_W-1:0]   sum;
		logic [LOAD_W-1:0]  low;
		logic [LOAD_W-1:0]  high;
	} stats_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_RESOLVE,
		ST_SWEEP,
		ST_READ,
		ST_UPDATE
	} state_t;

	// Which result the datapath presents
	typedef enum logic [1:0] {
		EMIT_EMPTY,
		EMIT_DROP,
		EMIT_ENTRY
	} emit_t;

	// Controller to datapath
	typedef struct packed {
		logic  capture;
		logic  hit_capture;
		logic  clear_used;
		logic  slot_capture;
		logic  insert;
		logic  sweep;
		logic  read;
		logic  update;
		logic  emit;
		emit_t emit_kind;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] req;
		logic       hit_any;
		logic       free_any;
		logic       sweep_last;
	} sts_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

// ===== src/per_thread_load_histogram_core.sv =====
// Top level of the per-thread load histogram: controller and datapath.
//
// One request is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done high, and must be taken
// then. A clear or an unused request code is answered from the lookup state, a
// read miss or a sample that finds the table full from the resolve state, and
// a read or a sample of a known thread passes through resolve, read and
// update, for a sample one read-modify-write of the stats and bin memories. A
// sample of a new thread also zeroes that entry's 51 bins one per cycle first.
// busy falls in the cycle in which the result is shown, so the next
// request can be taken then. The bin memory needs no clearing pass after
// reset: an entry's bins are zeroed when the entry is made.
module per_thread_load_histogram_core #(
	parameter int TABLE_ENTRIES = 32,
	parameter int FRACTION_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [63:0] thread_id,
	input  logic [15:0] load_sample,
	input  logic [5:0]  bin_select,
	output logic        done,
	output logic        found,
	output logic        dropped,
	output logic [4:0]  slot,
	output logic [31:0] samples_seen,
	output logic [31:0] busy_samples,
	output logic [39:0] load_sum,
	output logic [15:0] load_low,
	output logic [15:0] load_high,
	output logic [5:0]  bin_touched,
	output logic [31:0] bin_value
);

	import phl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	phl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	phl_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.thread_id    (thread_id),
		.load_sample  (load_sample),
		.bin_select   (bin_select),
		.done         (done),
		.found        (found),
		.dropped      (dropped),
		.slot         (slot),
		.samples_seen (samples_seen),
		.busy_samples (busy_samples),
		.load_sum     (load_sum),
		.load_low     (load_low),
		.load_high    (load_high),
		.bin_touched  (bin_touched),
		.bin_value    (bin_value)
	);

endmodule

// ===== src/phl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module phl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/phl_ctrl.sv =====
// Controller state machine of the per-thread load histogram.
module phl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  phl_pkg::sts_t sts,
	output phl_pkg::cmd_t cmd,
	output logic          busy
);

	import phl_pkg::*;

	state_t state_q;
	state_t state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands
	always_comb begin
		state_next = state_q;
		cmd = '0;
		cmd.emit_kind = EMIT_EMPTY;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_next = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (sts.req == REQ_CLEAR || sts.req == REQ_NONE) begin
					cmd.clear_used = (sts.req == REQ_CLEAR);
					cmd.emit = 1'b1;
					cmd.emit_kind = EMIT_EMPTY;
					state_next = ST_IDLE;
				end else begin
					cmd.hit_capture = 1'b1;
					state_next = ST_RESOLVE;
				end
			end
			ST_RESOLVE: begin
				cmd.slot_capture = 1'b1;
				if (sts.hit_any) begin
					state_next = ST_READ;
				end else if (sts.req == REQ_READ || !sts.free_any) begin
					// read miss or table full
					cmd.emit = 1'b1;
					cmd.emit_kind = EMIT_DROP;
					state_next = ST_IDLE;
				end else begin
					cmd.insert = 1'b1;
					state_next = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_next = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_next = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				cmd.emit = 1'b1;
				cmd.emit_kind = EMIT_ENTRY;
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

`ifndef NO_ASSERTIONS
	// A new entry is only made for a sample whose thread missed
	a_insert_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> (!sts.hit_any && sts.req == REQ_SAMPLE && sts.free_any))
		else $error("insert without a sample miss");

	// The bin row sweep is followed by the stats read
	a_sweep_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && sts.sweep_last) |=> (state_q == ST_READ))
		else $error("sweep did not hand over to read");

	// A request is taken only while idle
	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_LOOKUP && $past(state_q) == ST_IDLE))
		else $error("capture outside idle");
`endif

endmodule

// ===== src/phl_datapath.sv =====
// Datapath: key table, stats and bin memories, update arithmetic, result registers.
module phl_datapath #(
	parameter int TABLE_ENTRIES = 32,
	parameter int FRACTION_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  phl_pkg::cmd_t cmd,
	output phl_pkg::sts_t sts,
	input  logic [1:0]    req_type,
	input  logic [63:0]   thread_id,
	input  logic [15:0]   load_sample,
	input  logic [5:0]    bin_select,
	output logic          done,
	output logic          found,
	output logic          dropped,
	output logic [4:0]    slot,
	output logic [31:0]   samples_seen,
	output logic [31:0]   busy_samples,
	output logic [39:0]   load_sum,
	output logic [15:0]   load_low,
	output logic [15:0]   load_high,
	output logic [5:0]    bin_touched,
	output logic [31:0]   bin_value
);

	import phl_pkg::*;

	localparam int SlotW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int BinDepth = TABLE_ENTRIES * BIN_TOTAL;
	localparam int BinAw    = $clog2(BinDepth);
	localparam int WholeW   = LOAD_W - FRACTION_BITS;
	localparam int LowStartInt = LOW_START_PCT << FRACTION_BITS;
	localparam logic [LOAD_W-1:0] LowStart =
		(LowStartInt > 65535) ? 16'hFFFF : LOAD_W'(LowStartInt);

	// Captured request
	logic [1:0]        req_q;
	logic [KEY_W-1:0]  key_q;
	logic [LOAD_W-1:0] load_q;
	logic [BIN_W-1:0]  sel_q;

	// Key table
	logic [TABLE_ENTRIES-1:0] used_q;
	logic [KEY_W-1:0]         tkey_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] hit_q;

	logic [SlotW-1:0] hit_idx;
	logic [SlotW-1:0] free_idx;
	logic [SlotW-1:0] slot_next;
	logic             hit_any;
	logic             free_any;
	logic [SlotW-1:0] slot_q;
	logic             found_q;
	logic [BIN_W-1:0] sweep_q;

	// Memory ports
	logic              st_we;
	logic [SlotW-1:0]  st_waddr;
	stats_t            st_wdata;
	stats_t            st_rdata;
	logic              bn_we;
	logic [BinAw-1:0]  bn_waddr;
	logic [COUNT_W-1:0] bn_wdata;
	logic [BinAw-1:0]  bn_raddr;
	logic [COUNT_W-1:0] bn_rdata;
	logic [BinAw-1:0]  bin_base;

	// Update arithmetic
	logic [WholeW-1:0]  whole;
	logic [BIN_W-1:0]   samp_bin;
	logic [BIN_W-1:0]   rd_bin;
	logic               is_sample;
	logic               sel_ok;
	logic [SUM_W:0]     sum_wide;
	stats_t             st_new;
	logic [COUNT_W-1:0] bin_new;
	logic [SlotW+4:0]   slot_ext;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			key_q  <= thread_id;
			load_q <= load_sample;
			sel_q  <= bin_select;
		end
	end

	// Parallel key compare, registered
	always_ff @(posedge clk) begin
		if (cmd.hit_capture) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				hit_q[i] <= used_q[i] && (tkey_q[i] == key_q);
			end
		end
	end

	// Lowest matching and lowest free entry
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (hit_q[i]) begin
				hit_idx = SlotW'(i);
			end
			if (!used_q[i]) begin
				free_idx = SlotW'(i);
			end
		end
		hit_any   = |hit_q;
		free_any  = ~&used_q;
		slot_next = hit_any ? hit_idx : free_idx;
	end

	// Used bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.clear_used) begin
			used_q <= '0;
		end else if (cmd.insert) begin
			used_q[slot_next] <= 1'b1;
		end
	end

	// Keys, slot and sweep counter
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			tkey_q[slot_next] <= key_q;
		end
		if (cmd.slot_capture) begin
			slot_q  <= slot_next;
			found_q <= hit_any;
		end
		if (cmd.insert) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	// Bin index of the sample load, and of the read request
	always_comb begin
		whole     = load_q[LOAD_W-1:FRACTION_BITS];
		is_sample = (req_q == REQ_SAMPLE);
		sel_ok    = (sel_q <= IDLE_BIN);
		if (load_q == '0) begin
			samp_bin = IDLE_BIN;
		end else if (int'(whole) <= MAX_WHOLE_PCT) begin
			samp_bin = BIN_W'(whole / PCT_PER_BIN);
		end else begin
			samp_bin = NO_BIN;
		end
		if (is_sample) begin
			rd_bin = (samp_bin == NO_BIN) ? '0 : samp_bin;
		end else begin
			rd_bin = sel_ok ? sel_q : '0;
		end
	end

	assign bin_base = BinAw'(slot_q) * BinAw'(BIN_TOTAL);
	assign bn_raddr = bin_base + BinAw'(rd_bin);

	// New statistics from the entry read
	always_comb begin
		st_new = st_rdata;
		st_new.samples = sat_inc(st_rdata.samples);
		sum_wide = {1'b0, st_rdata.sum} + (SUM_W + 1)'(load_q);
		if (load_q != '0) begin
			st_new.sum  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
			st_new.busy = sat_inc(st_rdata.busy);
			if (st_rdata.low > load_q) begin
				st_new.low = load_q;
			end
			if (st_rdata.high < load_q) begin
				st_new.high = load_q;
			end
		end
		bin_new = sat_inc(bn_rdata);
	end

	// Stats memory write: initial values on insert, update on sample
	always_comb begin
		st_we    = cmd.insert || (cmd.update && is_sample);
		st_waddr = cmd.insert ? slot_next : slot_q;
		if (cmd.insert) begin
			st_wdata = '{samples: '0, busy: '0, sum: '0, low: LowStart, high: '0};
		end else begin
			st_wdata = st_new;
		end
	end

	// Bin memory write: zero sweep on insert, increment on sample
	always_comb begin
		bn_we    = cmd.sweep || (cmd.update && is_sample && samp_bin != NO_BIN);
		bn_waddr = cmd.sweep ? (bin_base + BinAw'(sweep_q)) : (bin_base + BinAw'(samp_bin));
		bn_wdata = cmd.sweep ? '0 : bin_new;
	end

	phl_ram #(
		.WIDTH ($bits(stats_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_stats_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (cmd.read),
		.raddr (slot_q),
		.rdata (st_rdata)
	);

	phl_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (BinDepth)
	) u_bin_ram (
		.clk   (clk),
		.we    (bn_we),
		.waddr (bn_waddr),
		.wdata (bn_wdata),
		.re    (cmd.read),
		.raddr (bn_raddr),
		.rdata (bn_rdata)
	);

	assign slot_ext = {5'b0, slot_q};

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			found        <= 1'b0;
			dropped      <= 1'b0;
			slot         <= '0;
			samples_seen <= '0;
			busy_samples <= '0;
			load_sum     <= '0;
			load_low     <= '0;
			load_high    <= '0;
			bin_touched  <= NO_BIN;
			bin_value    <= '0;
			case (cmd.emit_kind)
				EMIT_DROP: begin
					dropped <= 1'b1;
				end
				EMIT_ENTRY: begin
					found <= found_q;
					slot  <= slot_ext[4:0];
					if (is_sample) begin
						samples_seen <= st_new.samples;
						busy_samples <= st_new.busy;
						load_sum     <= st_new.sum;
						load_low     <= st_new.low;
						load_high    <= st_new.high;
						if (samp_bin != NO_BIN) begin
							bin_touched <= samp_bin;
							bin_value   <= bin_new;
						end
					end else begin
						samples_seen <= st_rdata.samples;
						busy_samples <= st_rdata.busy;
						load_sum     <= st_rdata.sum;
						load_low     <= st_rdata.low;
						load_high    <= st_rdata.high;
						if (sel_ok) begin
							bin_touched <= sel_q;
							bin_value   <= bn_rdata;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign sts.req        = req_q;
	assign sts.hit_any    = hit_any;
	assign sts.free_any   = free_any;
	assign sts.sweep_last = (sweep_q == BIN_W'(BIN_TOTAL - 1));

`ifndef NO_ASSERTIONS
	// A result strobe is never followed straight away by another
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held two cycles");

	// A matching slot is a used one
	a_hit_used: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.slot_capture && hit_any) |-> used_q[slot_next])
		else $error("hit on an unused entry");

	// The row sweep stays inside one entry's bins
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> (sweep_q < BIN_W'(BIN_TOTAL)))
		else $error("bin sweep ran past the row");
`endif

endmodule
